// ===== hw/rtl/nearest_palette_color_defines.svh =====
// Assertion macros shared by the nearest palette colour RTL.
`ifndef NEAREST_PALETTE_COLOR_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/npc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

  localparam int PALETTE_DEPTH = 16;
  localparam int IDX_W         = 4;
  localparam int LEN_W         = 5;
  localparam int COLOR_W       = 24;
  localparam int DIST_W        = 18;

  // Larger than any real distance (3 * 255 * 255 = 195075).
  localparam logic [DIST_W-1:0] NO_MATCH_DIST = 18'd195076;
  localparam logic [DIST_W-1:0] MAX_DIST      = 18'd195075;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_REG_LENGTH = 1'b0;

  typedef logic [IDX_W-1:0] idx_t;

  // One word travelling along the cell chain, with its running best match.
  typedef struct packed {
    logic                valid;
    logic                is_query;
    logic [IDX_W-1:0]    entry_index;
    logic [COLOR_W-1:0]  color;
    logic [IDX_W-1:0]    best_idx;
    logic [DIST_W-1:0]   best_dist;
  } npc_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/npc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_palette_color_defines.svh"

module npc_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          advance,
  input  wire npc_pkg::idx_t           cell_idx,
  input  wire [npc_pkg::LEN_W-1:0]     palette_len,
  input  wire npc_pkg::npc_item_t      s_in,
  output npc_pkg::npc_item_t           s_out
);

  logic [npc_pkg::COLOR_W-1:0] entry_r;
  npc_pkg::npc_item_t          s_r;
  npc_pkg::npc_item_t          s_nxt;

  logic [7:0]                  d_red, d_grn, d_blu;
  logic [15:0]                 sq_red, sq_grn, sq_blu;
  logic [npc_pkg::DIST_W-1:0]  sq_dist;
  logic                        active;
  logic                        hit_write;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    d_red   = abs_diff(s_in.color[23:16], entry_r[23:16]);
    d_grn   = abs_diff(s_in.color[15:8],  entry_r[15:8]);
    d_blu   = abs_diff(s_in.color[7:0],   entry_r[7:0]);
    sq_red  = d_red * d_red;
    sq_grn  = d_grn * d_grn;
    sq_blu  = d_blu * d_blu;
    sq_dist = npc_pkg::DIST_W'(sq_red) + npc_pkg::DIST_W'(sq_grn)
            + npc_pkg::DIST_W'(sq_blu);
  end

  // Only the first palette_len cells take part in a search.
  assign active    = s_in.valid && (s_in.is_query == npc_pkg::REQ_QUERY)
                     && ({1'b0, cell_idx} < palette_len);
  assign hit_write = s_in.valid && (s_in.is_query == npc_pkg::REQ_WRITE)
                     && (s_in.entry_index == cell_idx);

  always_comb begin
    s_nxt = s_in;
    if (active && (sq_dist < s_in.best_dist)) begin
      s_nxt.best_idx  = cell_idx;
      s_nxt.best_dist = sq_dist;
    end
  end

  // A write updates the entry as it passes; later queries see the new colour.
  always_ff @(posedge clk) begin
    if (advance && hit_write) begin
      entry_r <= s_in.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (advance) begin
      s_r.valid <= s_nxt.valid;
    end
    if (advance) begin
      s_r.is_query    <= s_nxt.is_query;
      s_r.entry_index <= s_nxt.entry_index;
      s_r.color       <= s_nxt.color;
      s_r.best_idx    <= s_nxt.best_idx;
      s_r.best_dist   <= s_nxt.best_dist;
    end
  end

  assign s_out = s_r;

  `NPC_ASSERT_NEXT(a_dist_never_grows, clk, rst_n,
    advance && s_in.valid && s_in.is_query,
    s_r.best_dist <= $past(s_in.best_dist), "running best distance grew in a cell")
  `NPC_ASSERT_NEXT(a_write_stored, clk, rst_n,
    advance && hit_write,
    entry_r == $past(s_in.color), "palette write was not stored in its cell")
  `NPC_ASSERT_NEXT(a_stall_holds, clk, rst_n,
    !advance,
    s_r == $past(s_r), "cell stage changed while the chain was stalled")

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_palette_color.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_palette_color_defines.svh"

// Channel   Direction  Contents
// in_       slave      tdata: entry_index, rgb_color; tuser: req_type
// out_      master     tdata: nearest_index, best_distance
// cfg_      APB slave  register 0 at byte address 0: palette_length
//
// Every word, write or query, walks the chain of sixteen cells in order, and a
// query result is registered in each of the sixteen cells and then in the
// output register. One word is accepted per cycle while the chain advances;
// throughput is set by the cell chain advancing as a single shift line.
// When a result waits in the output register and out_tready is low, the whole
// chain freezes and in_tready drops. Reset clears the valid flags and sets
// palette_length to 16; palette entries are not cleared and must be written
// before they are searched.

module nearest_palette_color (
  input  wire         clk,
  input  wire         rst_n,
  // Input words.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [3:0] entry_index, [27:4] rgb_color, [31:28] zero
  input  wire  [0:0]  in_tuser,   // [0] req_type
  // Result words.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [3:0] nearest_index, [21:4] best_distance, [23:22] zero
  // Configuration.
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [npc_pkg::LEN_W-1:0]  palette_len_r;
  logic                       advance;
  npc_pkg::npc_item_t         stage [0:npc_pkg::PALETTE_DEPTH];
  npc_pkg::npc_item_t         last;

  logic                       out_valid_r;
  logic [npc_pkg::IDX_W-1:0]  out_idx_r;
  logic [npc_pkg::DIST_W-1:0] out_dist_r;
  logic [npc_pkg::DIST_W-1:0] final_dist;

  // Configuration port: always ready, one register selected by word address.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_len_r <= npc_pkg::LEN_W'(npc_pkg::PALETTE_DEPTH);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == npc_pkg::CFG_REG_LENGTH)) begin
      palette_len_r <= cfg_pwdata[npc_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == npc_pkg::CFG_REG_LENGTH) begin
      cfg_prdata = {{(32 - npc_pkg::LEN_W){1'b0}}, palette_len_r};
    end
  end

  // The chain moves whenever the output register is free or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  always_comb begin
    stage[0].valid       = in_tvalid && in_tready;
    stage[0].is_query    = in_tuser[0];
    stage[0].entry_index = in_tdata[3:0];
    stage[0].color       = in_tdata[27:4];
    stage[0].best_idx    = '0;
    stage[0].best_dist   = npc_pkg::NO_MATCH_DIST;
  end

  for (genvar g = 0; g < npc_pkg::PALETTE_DEPTH; g++) begin : g_cell
    npc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .advance     (advance),
      .cell_idx    (npc_pkg::idx_t'(g)),
      .palette_len (palette_len_r),
      .s_in        (stage[g]),
      .s_out       (stage[g+1])
    );
  end

  assign last = stage[npc_pkg::PALETTE_DEPTH];

  // A query that found no active entry (empty palette) reports distance zero.
  assign final_dist = (last.best_dist == npc_pkg::NO_MATCH_DIST) ? '0 : last.best_dist;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last.valid && (last.is_query == npc_pkg::REQ_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_idx_r  <= last.best_idx;
      out_dist_r <= final_dist;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_dist_r, out_idx_r};

  `NPC_ASSERT_NOW(a_dist_in_range, clk, rst_n,
    out_valid_r,
    out_dist_r <= npc_pkg::MAX_DIST, "result distance out of range")
  `NPC_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
    out_valid_r && !out_tready,
    !in_tready, "input accepted while the result register is blocked")
  `NPC_ASSERT_NEXT(a_query_reaches_output, clk, rst_n,
    advance && last.valid && (last.is_query == npc_pkg::REQ_QUERY),
    out_valid_r, "query left the chain without producing a result")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Testbench for nearest_palette_color. Palette writes and colour queries are
// streamed into the block while a scoreboard keeps its own copy of the
// palette and of palette_length. For every query word it works out the
// nearest entry and its squared distance, and each result word is checked
// against the oldest of those predictions.
module testbench;
  import npc_pkg::*;

  // Byte addresses of the configuration registers. Only index 0 exists; the
  // next slot is written once to show that it changes nothing.
  localparam logic [2:0] ADDR_LENGTH = 3'(4 * CFG_REG_LENGTH);
  localparam logic [2:0] ADDR_SPARE  = 3'd4;
  // A write word walks all sixteen cells and gives no result, so the block
  // may still be busy once the last result has come. Wait this long.
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 200;

  // Keeps the palette as it should stand and the queue of pending matches.
  class palette_scoreboard;
    logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
    logic [LEN_W-1:0]   length;
    idx_t               want_index [$];
    logic [DIST_W-1:0]  want_dist [$];
    int                 mismatches;
    int                 results;
    int                 writes;
    int                 queries;

    function new();
      foreach (palette[i]) palette[i] = '0;
      length     = LEN_W'(PALETTE_DEPTH);
      mismatches = 0;
      results    = 0;
      writes     = 0;
      queries    = 0;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    function int pending();
      return want_index.size();
    endfunction

    function int colour_gap(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
      int sum;
      int d;
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
        sum += d * d;
      end
      return sum;
    endfunction

    // Lowest index wins on a tie, since only a strictly smaller distance
    // replaces the running best.
    function void nearest_entry(input logic [COLOR_W-1:0] colour,
                                output idx_t idx, output logic [DIST_W-1:0] gap);
      int span;
      int best;
      int d;
      span = (int'(length) > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(length);
      idx  = '0;
      best = int'(NO_MATCH_DIST);
      for (int i = 0; i < span; i++) begin
        d = colour_gap(colour, palette[i]);
        if (d < best) begin
          best = d;
          idx  = idx_t'(i);
        end
      end
      if (span == 0) best = 0;
      gap = DIST_W'(best);
    endfunction

    function void note_word(logic req, idx_t slot, logic [COLOR_W-1:0] colour);
      idx_t              idx;
      logic [DIST_W-1:0] gap;
      if (req == REQ_WRITE) begin
        palette[slot] = colour;
        writes++;
      end else begin
        nearest_entry(colour, idx, gap);
        want_index.push_back(idx);
        want_dist.push_back(gap);
        queries++;
      end
    endfunction

    task check_word(logic [23:0] data);
      idx_t              got_idx;
      logic [DIST_W-1:0] got_dist;
      idx_t              exp_idx;
      logic [DIST_W-1:0] exp_dist;
      got_idx  = data[IDX_W-1:0];
      got_dist = data[IDX_W +: DIST_W];
      if (want_index.size() == 0) begin
        report($sformatf("result word %0d/%0d with no query waiting", got_idx, got_dist));
      end else begin
        exp_idx  = want_index.pop_front();
        exp_dist = want_dist.pop_front();
        results++;
        if (got_idx !== exp_idx)
          report($sformatf("nearest_index %0d, expected %0d", got_idx, exp_idx));
        if (got_dist !== exp_dist)
          report($sformatf("best_distance %0d, expected %0d", got_dist, exp_dist));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [3:0] entry_index, [27:4] rgb_color, [31:28] zero
  logic [0:0]  in_tuser = '0;    // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [3:0] nearest_index, [21:4] best_distance, [23:22] zero
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // While calm is set neither side idles, so the chain runs at full rate.
  logic        calm = 1'b0;
  int          settings = 0;

  palette_scoreboard sb = new();

  nearest_palette_color u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random, about seven percent of the time.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 7);
  end

  // Both channels are watched at the clock edge itself. Inputs are driven by
  // nonblocking assignments, so the values seen here are those of the edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_word(in_tuser[0], in_tdata[IDX_W-1:0], in_tdata[IDX_W +: COLOR_W]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata);
  end

  // Offers one word and returns at the edge that accepts it. in_tvalid is
  // left high so that a following word can go out in the very next cycle.
  task automatic send_word(logic req, idx_t slot, logic [COLOR_W-1:0] colour);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(32 - IDX_W - COLOR_W){1'b0}}, colour, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic sender_gap(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending until every query has been answered and any trailing write
  // has left the chain, so that the block is idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes a register, then reads palette_length straight back in an
  // access that follows at once, and compares it with the expected value.
  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ADDR_LENGTH) begin
      sb.length = value[LEN_W-1:0];
      settings++;
    end
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_LENGTH;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[LEN_W-1:0] !== sb.length)
      sb.report($sformatf("palette_length reads %0d, expected %0d",
                          cfg_prdata[LEN_W-1:0], sb.length));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // One random word. Most queries land close to a palette entry, so that
  // small distances and ties between equal entries come up often.
  task automatic random_word();
    logic [COLOR_W-1:0] colour;
    logic [COLOR_W-1:0] anchor;
    idx_t               slot;
    int                 pick;
    int                 chan;
    slot   = idx_t'($urandom_range(PALETTE_DEPTH - 1));
    pick   = $urandom_range(99);
    colour = COLOR_W'($urandom);
    anchor = sb.palette[$urandom_range(PALETTE_DEPTH - 1)];
    if (pick < 35) begin
      if ($urandom_range(4) == 0) colour = anchor;
      send_word(REQ_WRITE, slot, colour);
    end else begin
      if (pick < 70) begin
        for (int c = 0; c < 3; c++) begin
          chan = int'(anchor[8*c +: 8]) + $urandom_range(12) - 6;
          chan = (chan < 0) ? 0 : (chan > 255) ? 255 : chan;
          colour[8*c +: 8] = 8'(chan);
        end
      end else if (pick < 82) begin
        colour = anchor;
      end else if (pick < 86) begin
        colour = ($urandom_range(1) == 0) ? '0 : '1;
      end
      send_word(REQ_QUERY, slot, colour);
    end
    if (!calm && $urandom_range(99) < 7) sender_gap(1);
  endtask

  initial begin
    logic [LEN_W-1:0] phase_length [PHASES];

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The unused register slot must leave the reset length of sixteen alone.
    reg_write(ADDR_SPARE, 32'h0000_0005);

    // Empty palette: nothing is searched, so nothing need be written yet.
    reg_write(ADDR_LENGTH, 32'd0);
    send_word(REQ_QUERY, 4'h0, 24'h000000);
    send_word(REQ_QUERY, 4'hF, 24'hFFFFFF);

    // A single black entry: a white query gives the largest distance there is.
    send_word(REQ_WRITE, 4'h0, 24'h000000);
    settle();
    reg_write(ADDR_LENGTH, 32'd1);
    send_word(REQ_QUERY, 4'h5, 24'hFFFFFF);
    send_word(REQ_QUERY, 4'hA, 24'h000000);
    send_word(REQ_QUERY, 4'h3, 24'h808080);

    // Fill the rest. Slot 1 repeats slot 0, so a black query ties and must
    // keep the lower index; slot 15 is white.
    send_word(REQ_WRITE, 4'hF, 24'hFFFFFF);
    send_word(REQ_WRITE, 4'h1, 24'h000000);
    for (int i = 2; i < PALETTE_DEPTH - 1; i++)
      send_word(REQ_WRITE, idx_t'(i), COLOR_W'($urandom));
    settle();

    // A length beyond the palette depth is clamped to the whole palette.
    reg_write(ADDR_LENGTH, 32'd31);
    send_word(REQ_QUERY, 4'h0, 24'h000000);
    send_word(REQ_QUERY, 4'h0, 24'hFFFFFF);
    send_word(REQ_QUERY, 4'h9, COLOR_W'($urandom));
    settle();

    // Random phases, each under its own length; the second one runs with
    // no idling on either side.
    phase_length[0] = LEN_W'(PALETTE_DEPTH);
    phase_length[1] = LEN_W'(PALETTE_DEPTH);
    phase_length[2] = LEN_W'($urandom_range(2, PALETTE_DEPTH - 1));
    phase_length[3] = LEN_W'(1);
    phase_length[4] = LEN_W'($urandom_range(PALETTE_DEPTH + 1, 31));
    phase_length[5] = LEN_W'($urandom_range(1, PALETTE_DEPTH));
    for (int p = 0; p < PHASES; p++) begin
      reg_write(ADDR_LENGTH, 32'(phase_length[p]));
      calm = (p == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Once, mid-phase, hold back until every query has been answered.
        if (p == 2 && n == PHASE_WORDS / 2) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.pending() > 0) @(posedge clk);
        end
        random_word();
      end
      calm = 1'b0;
      settle();
    end

    $display("Run covered %0d palette writes and %0d queries under %0d length settings,",
             sb.writes, sb.queries, settings);
    $display("with %0d result words checked against the predicted nearest entries.",
             sb.results);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2_400_000;
    $display("Timed out with %0d results outstanding.", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/npc_pkg.sv
hw/rtl/npc_cell.sv
hw/rtl/nearest_palette_color.sv
tb/testbench.sv
